>>> rtl/core/three_stage_biquad_eq_with_boost_core_defines.svh
// Assertion macros shared by the core
`ifndef THREE_STAGE_BIQUAD_EQ_WITH_BOOST_CORE_DEFINES_SVH
`define THREE_STAGE_BIQUAD_EQ_WITH_BOOST_CORE_DEFINES_SVH
// implication checked on every edge outside reset
`define TBQ_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("tbq check");
// next-cycle implication
`define TBQ_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("tbq check");
`endif

>>> rtl/core/tbq_pkg.sv
package tbq_pkg;
  localparam int SAMPLE_W = 24;
  localparam int COEF_W = 32;
  localparam int GAIN_W = 16;
  localparam int CPS = 5;
  localparam int DEF_STREAMS = 8;
  localparam int DEF_STAGES = 3;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_COEF = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_BOOST = 2'd1;
  localparam logic [1:0] REG_EQ = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  stream;
    logic signed [23:0] sample_in;
    logic [3:0]  coef_index;
    logic signed [31:0] coef_value;
  } tbq_in_t;

  typedef struct packed {
    logic [2:0]  stream_out;
    logic signed [23:0] sample_out;
    logic        saturated;
  } tbq_out_t;
endpackage

>>> rtl/core/three_stage_biquad_eq_with_boost_core.sv
// Tone control core: each sample transfer is optionally boosted (unsigned Q4.12 gain,
// rounded half up and clamped to Q1.23) and then, with EQ on, run through STAGES
// direct form 1 biquads with per-stream history; the result is saturated to the
// sample range. Coefficient transfers load one shared Q4.28 coefficient, clear
// transfers zero one stream's history, and neither returns a result. All products
// are formed on one shift-and-add unit, one multiplier bit a cycle. With both paths
// on, a sample is decoded, boosted bit by bit over the sixteen gain bits, rounded
// and clamped; then per stage the stage address is set, the four history words are
// read, the five 32-bit products are accumulated, the sum is rounded and clamped and
// the four history words are written back; last the output is loaded and the result
// is transferred. Transfers of other types or to a stream out of range are ignored.
// A stalled result holds the core, and the next item is taken only once the result
// has gone. After reset all STREAMS*STAGES*4 history words (96 by default) are
// cleared before any item is accepted; configuration writes are taken at any time.
module three_stage_biquad_eq_with_boost_core
  import tbq_pkg::*;
#(
  parameter int STREAMS = DEF_STREAMS,
  parameter int STAGES = DEF_STAGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  tbq_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tbq_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
`include "three_stage_biquad_eq_with_boost_core_defines.svh"

  localparam int NCOEF = STAGES * CPS;
  localparam int CI_W = (NCOEF > 1) ? $clog2(NCOEF) : 1;
  localparam int NHIST = STREAMS * STAGES * 4;
  localparam int HA_W = (NHIST > 1) ? $clog2(NHIST) : 1;
  localparam int SG_W = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int HW_W = (STAGES * 4 > 1) ? $clog2(STAGES * 4) : 1;
  localparam logic signed [63:0] HMAX = 64'sd134217727;
  localparam logic signed [63:0] HMIN = -64'sd134217728;
  localparam logic signed [63:0] SMAX = 64'sd8388607;
  localparam logic signed [63:0] SMIN = -64'sd8388608;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_BMUL, S_BFIN, S_LOAD, S_RDW, S_MUL, S_SFIN,
    S_WB, S_FIN, S_HOLD, S_WIPE
  } state_t;

  // configuration registers
  logic [15:0] boost_gain;
  logic        boost_enable, eq_enable;
  logic [1:0]  reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      boost_gain <= 16'd4096;
      boost_enable <= 1'b0;
      eq_enable <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_GAIN: boost_gain <= pwdata[15:0];
        REG_BOOST: boost_enable <= pwdata[0];
        REG_EQ: eq_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN: prdata = {16'd0, boost_gain};
      REG_BOOST: prdata = {31'd0, boost_enable};
      REG_EQ: prdata = {31'd0, eq_enable};
      default: prdata = 32'd0;
    endcase
  end

  // coefficient registers (small, read at one counter-chosen place)
  logic signed [31:0] coef [NCOEF];

  // history memory: per word index = (stream*STAGES+stage)*4 + {x1,x2,y1,y2}
  logic signed [31:0] hist [NHIST];
  logic [HA_W-1:0] h_addr;
  logic            h_we;
  logic signed [31:0] h_wdata, h_rdata;

  always_ff @(posedge clk) begin
    if (h_we) hist[h_addr] <= h_wdata;
    h_rdata <= hist[h_addr];
  end

  state_t state;
  tbq_in_t item;
  logic [HA_W-1:0] clr_cnt;
  logic [HW_W-1:0] wcnt;
  logic [1:0] wk;
  logic [SG_W-1:0] stg;
  logic [2:0] term;
  logic [4:0] bitc;
  logic signed [31:0] h0, h1, h2, h3;   // x1 x2 y1 y2 of the current stage
  logic signed [31:0] x;                // current stage input
  logic signed [63:0] acc;
  logic signed [63:0] mcand;            // shifted multiplicand
  logic [31:0] mplier;                  // multiplier bits, shifted out LSB first
  logic        hit;
  logic [2:0]  rdc;
  logic [HA_W-1:0] base;

  assign base = HA_W'((32'(item.stream) * STAGES + 32'(stg)) * 4);
  assign in_stall = (state != S_IDLE);

  // one serial step: the multiplier's sign bit carries negative weight
  logic signed [63:0] step_acc;
  logic last_bit;
  assign last_bit = (bitc == 5'd31);
  always_comb begin
    step_acc = acc;
    if (mplier[0]) step_acc = last_bit ? acc - mcand : acc + mcand;
  end

  // rounding helper: add half, then floor shift
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  logic signed [63:0] st_y, bst_x;
  assign st_y = rnd(acc, 28);
  assign bst_x = rnd(acc, 12);

  // operands of the term to load: b0*x, b1*x1, b2*x2, a1*(-y1), a2*(-y2)
  logic [2:0] opi;
  logic [CI_W-1:0] cf_idx;
  logic signed [31:0] t_op;
  logic signed [31:0] t_cf;
  assign opi = (state == S_MUL) ? term + 3'd1 : 3'd0;
  always_comb begin
    case (opi)
      3'd0: t_op = x;
      3'd1: t_op = h0;
      3'd2: t_op = h1;
      3'd3: t_op = -h2;
      default: t_op = -h3;
    endcase
    cf_idx = (32'(opi) < CPS) ? CI_W'(32'(stg) * CPS + 32'(opi)) : '0;
    t_cf = coef[cf_idx];
  end

  // history word written back in each write cycle
  logic signed [31:0] wb_word;
  always_comb begin
    case (wk)
      2'd0: wb_word = h0;
      2'd1: wb_word = h1;
      2'd2: wb_word = h2;
      default: wb_word = h3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NCOEF; i++) coef[i] <= (i % CPS == 0) ? 32'sh1000_0000 : 32'sd0;
      h_addr <= '0;
      h_we <= 1'b0;
    end else begin
      h_we <= (state == S_CLR) || (state == S_WIPE) || (state == S_WB);
      h_wdata <= (state == S_WB) ? wb_word : 32'sd0;
      unique case (state)
        S_CLR: begin
          h_addr <= clr_cnt;
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == HA_W'(NHIST - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          hit <= 1'b0;
          x <= 32'(item.sample_in);
          stg <= '0;
          wcnt <= '0;
          if (item.req_type == REQ_COEF) begin
            if (32'(item.coef_index) < NCOEF)
              coef[CI_W'(item.coef_index)] <= item.coef_value;
            state <= S_IDLE;
          end else if ((item.req_type != REQ_SAMPLE && item.req_type != REQ_CLEAR) ||
                       32'(item.stream) >= STREAMS) begin
            state <= S_IDLE;
          end else if (item.req_type == REQ_CLEAR) begin
            state <= S_WIPE;
          end else if (boost_enable) begin
            acc <= '0;
            mcand <= 64'(item.sample_in);
            mplier <= {16'd0, boost_gain};
            bitc <= '0;
            state <= S_BMUL;
          end else if (eq_enable) begin
            state <= S_LOAD;
          end else begin
            state <= S_FIN;
          end
        end
        S_WIPE: begin
          h_addr <= HA_W'(32'(item.stream) * STAGES * 4 + 32'(wcnt));
          wcnt <= wcnt + 1'b1;
          if (wcnt == HW_W'(STAGES * 4 - 1)) state <= S_IDLE;
        end
        // unsigned gain, sixteen bits
        S_BMUL: begin
          acc <= acc + (mplier[0] ? mcand : 64'sd0);
          mcand <= mcand <<< 1;
          mplier <= mplier >> 1;
          bitc <= bitc + 1'b1;
          if (bitc == 5'd15) state <= S_BFIN;
        end
        S_BFIN: begin
          if (bst_x > SMAX) begin x <= 32'(SMAX); hit <= 1'b1; end
          else if (bst_x < SMIN) begin x <= 32'(SMIN); hit <= 1'b1; end
          else x <= 32'(bst_x);
          state <= eq_enable ? S_LOAD : S_FIN;
        end
        // read the four history words of this stage
        S_LOAD: begin
          h_addr <= base;
          rdc <= '0;
          state <= S_RDW;
        end
        S_RDW: begin
          rdc <= rdc + 1'b1;
          if (rdc < 3'd3) h_addr <= h_addr + 1'b1;
          case (rdc)
            3'd1: h0 <= h_rdata;
            3'd2: h1 <= h_rdata;
            3'd3: h2 <= h_rdata;
            3'd4: begin
              // last word in: start the b0 term
              h3 <= h_rdata;
              acc <= '0;
              term <= '0;
              bitc <= '0;
              mcand <= 64'(t_op);
              mplier <= t_cf;
              state <= S_MUL;
            end
            default: ;
          endcase
        end
        S_MUL: begin
          acc <= step_acc;
          if (last_bit) begin
            if (term == 3'd4) state <= S_SFIN;
            else begin
              term <= term + 1'b1;
              bitc <= '0;
              mcand <= 64'(t_op);
              mplier <= t_cf;
            end
          end else begin
            bitc <= bitc + 1'b1;
            mcand <= mcand <<< 1;
            mplier <= mplier >> 1;
          end
        end
        // round and clamp the stage output, shift the history
        S_SFIN: begin
          h1 <= h0;
          h0 <= x;
          h3 <= h2;
          if (st_y > HMAX) begin h2 <= 32'(HMAX); hit <= 1'b1; end
          else if (st_y < HMIN) begin h2 <= 32'(HMIN); hit <= 1'b1; end
          else h2 <= 32'(st_y);
          wk <= '0;
          state <= S_WB;
        end
        // write back x1, x2, y1, y2
        S_WB: begin
          h_addr <= base + HA_W'(wk);
          wk <= wk + 1'b1;
          if (wk == 2'd3) begin
            if (32'(stg) == STAGES - 1) begin
              if (64'(h2) > SMAX) begin x <= 32'(SMAX); hit <= 1'b1; end
              else if (64'(h2) < SMIN) begin x <= 32'(SMIN); hit <= 1'b1; end
              else x <= h2;
              state <= S_FIN;
            end else begin
              x <= h2;
              stg <= stg + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        S_FIN: begin
          out_data.stream_out <= item.stream;
          out_data.sample_out <= x[23:0];
          out_data.saturated <= hit;
          out_valid <= 1'b1;
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TBQ_ASSERT_IMP(a_stall_busy, out_valid, in_stall)
  `TBQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `TBQ_ASSERT_IMP(a_no_accept_clr, state == S_CLR, in_stall)

endmodule
